// File: hdl/pdw_pkg.sv
`default_nettype none

package pdw_pkg;

	localparam int MAX_FIELD_WIDTH_DEF = 20;
	localparam int VALUE_BITS_DEF      = 32;

	localparam int NUMBER_W      = 32;
	localparam int FIELD_WIDTH_W = 5;
	localparam int COORD_W       = 8;
	localparam int SYMBOL_W      = 8;
	localparam int DIGIT_W       = 4;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 24;

	localparam logic [7:0] PAD_RESET = 8'd48;

	localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

endpackage

`default_nettype wire

// File: hdl/padded_decimal_digit_writer.sv
// Prints an unsigned number as a run of decimal character cells.
// Input stream (s_*): one transaction per number; column, row, value and field
// width in s_tdata. Config channel (cfg_*): pad character, always ready; write
// only while the block is idle. Pad character zero turns padding off.
// Output stream (m_*): one transaction per cell, most significant first:
// pad cells (m_tuser high) then digits; m_tlast marks the final digit.
// After acceptance the value goes through a bit-serial double-dabble
// converter, one bit per cycle, then leading zero digits are dropped one per
// cycle, then one cell is issued per cycle while the receiver is ready.
// One number is handled at a time; s_tready is
// low from acceptance until the last cell is loaded into the output register.
// A stalled receiver holds the output register and freezes cell issue.
// Reset clears the control state and sets the pad character to '0' (48).
`default_nettype none

module padded_decimal_digit_writer
	import pdw_pkg::*;
#(
	parameter int MAX_FIELD_WIDTH = MAX_FIELD_WIDTH_DEF,
	parameter int VALUE_BITS      = VALUE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// [7:0] start_column, [15:8] screen_row, [47:16] number, [52:48] field_width
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [7:0] cell_column, [15:8] cell_row, [23:16] symbol
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// [0] is_pad
	output logic                        m_tuser,
	output logic                        m_tlast,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [SYMBOL_W-1:0]    cfg_data
);

	localparam int CB   = (VALUE_BITS < NUMBER_W) ? VALUE_BITS : NUMBER_W;
	localparam int NDIG = (CB + 2) / 3;
	localparam int DW   = $clog2(NDIG + 1);
	localparam int MXC  = (MAX_FIELD_WIDTH > NDIG) ? MAX_FIELD_WIDTH : NDIG;
	localparam int CW   = $clog2(MXC + 1);
	localparam int XW   = (CW > FIELD_WIDTH_W) ? CW : FIELD_WIDTH_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} pdw_state_t;

	pdw_state_t              state_q;
	logic [SYMBOL_W-1:0]     pad_char_q;
	logic [COORD_W-1:0]      col_q;
	logic [COORD_W-1:0]      row_q;
	logic [XW-1:0]           width_q;
	logic [XW-1:0]           pad_left_q;
	logic [DW-1:0]           dig_left_q;
	logic [NDIG*DIGIT_W-1:0] bcd_q;

	logic                    m_tvalid_q;
	logic [COORD_W-1:0]      m_col_q;
	logic [COORD_W-1:0]      m_row_q;
	logic [SYMBOL_W-1:0]     m_sym_q;
	logic                    m_pad_q;
	logic                    m_last_q;

	logic                    accept;
	logic                    step;
	logic [XW-1:0]           width_in;
	logic [XW-1:0]           width_sat;
	logic [XW-1:0]           npad;
	logic                    dab_done;
	logic [NDIG*DIGIT_W-1:0] dab_bcd;
	logic [DW-1:0]           dab_ndig;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign step      = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	assign width_in  = XW'(s_tdata[48 +: FIELD_WIDTH_W]);
	assign width_sat = (width_in > XW'(MAX_FIELD_WIDTH)) ? XW'(MAX_FIELD_WIDTH) : width_in;
	assign npad      = (pad_char_q != '0 && width_q > XW'(dab_ndig)) ?
	                   width_q - XW'(dab_ndig) : '0;

	pdw_dabble #(
		.CONV_BITS (CB),
		.NDIG      (NDIG),
		.DW        (DW)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (s_tdata[16 +: CB]),
		.done   (dab_done),
		.bcd    (dab_bcd),
		.ndig   (dab_ndig)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pad_char_q <= PAD_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pad_char_q <= cfg_data;
			end
			if (step) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (dab_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (step && pad_left_q == '0 && dig_left_q == DW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q   <= s_tdata[0 +: COORD_W];
			row_q   <= s_tdata[COORD_W +: COORD_W];
			width_q <= width_sat;
		end
		if (state_q == ST_CONV && dab_done) begin
			bcd_q      <= dab_bcd;
			dig_left_q <= dab_ndig;
			pad_left_q <= npad;
		end
		if (step) begin
			m_col_q <= col_q;
			m_row_q <= row_q;
			col_q   <= col_q + COORD_W'(1);
			if (pad_left_q != '0) begin
				m_sym_q    <= pad_char_q;
				m_pad_q    <= 1'b1;
				m_last_q   <= 1'b0;
				pad_left_q <= pad_left_q - XW'(1);
			end else begin
				m_sym_q    <= SYMBOL_W'(bcd_q[NDIG*DIGIT_W-1 -: DIGIT_W]);
				m_pad_q    <= 1'b0;
				m_last_q   <= (dig_left_q == DW'(1));
				bcd_q      <= {bcd_q[NDIG*DIGIT_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
				dig_left_q <= dig_left_q - DW'(1);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_sym_q, m_row_q, m_col_q};
	assign m_tuser  = m_pad_q;
	assign m_tlast  = m_last_q;

endmodule

`default_nettype wire

// File: hdl/pdw_dabble.sv
`default_nettype none

module pdw_dabble
	import pdw_pkg::*;
#(
	parameter int CONV_BITS = VALUE_BITS_DEF,
	parameter int NDIG      = (VALUE_BITS_DEF + 2) / 3,
	parameter int DW        = $clog2(NDIG + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [CONV_BITS-1:0]      value,
	output logic                           done,
	output logic [NDIG*DIGIT_W-1:0]        bcd,
	output logic [DW-1:0]                  ndig
);

	localparam int CNTW = $clog2(CONV_BITS + 1);

	typedef enum logic [2:0] {
		DAB_IDLE  = 3'b001,
		DAB_CONV  = 3'b010,
		DAB_STRIP = 3'b100
	} dab_state_t;

	dab_state_t                 state_q;
	logic [CONV_BITS-1:0]       bin_q;
	logic [NDIG*DIGIT_W-1:0]    bcd_q;
	logic [NDIG*DIGIT_W-1:0]    adj;
	logic [CNTW-1:0]            cnt_q;
	logic [DW-1:0]              ndig_q;
	logic                       done_q;

	// add-3 correction on every digit before the shift
	always_comb begin
		logic [DIGIT_W-1:0] d;
		for (int i = 0; i < NDIG; i++) begin
			d = bcd_q[i*DIGIT_W +: DIGIT_W];
			adj[i*DIGIT_W +: DIGIT_W] = (d >= DABBLE_LIMIT) ? d + DABBLE_ADD : d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DAB_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DAB_IDLE: begin
					if (start) begin
						state_q <= DAB_CONV;
					end
				end
				DAB_CONV: begin
					if (cnt_q == CNTW'(1)) begin
						state_q <= DAB_STRIP;
					end
				end
				DAB_STRIP: begin
					if (!(ndig_q > DW'(1) && bcd_q[NDIG*DIGIT_W-1 -: DIGIT_W] == '0)) begin
						state_q <= DAB_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= DAB_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DAB_IDLE: begin
				bin_q  <= value;
				bcd_q  <= '0;
				cnt_q  <= CNTW'(CONV_BITS);
				ndig_q <= DW'(NDIG);
			end
			DAB_CONV: begin
				bcd_q <= {adj[NDIG*DIGIT_W-2:0], bin_q[CONV_BITS-1]};
				bin_q <= {bin_q[CONV_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - CNTW'(1);
			end
			DAB_STRIP: begin
				if (ndig_q > DW'(1) && bcd_q[NDIG*DIGIT_W-1 -: DIGIT_W] == '0) begin
					bcd_q  <= {bcd_q[NDIG*DIGIT_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
					ndig_q <= ndig_q - DW'(1);
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign bcd  = bcd_q;
	assign ndig = ndig_q;

endmodule

`default_nettype wire

// File: hdl/pdw_checker.sv
`default_nettype none

module pdw_checker
	import pdw_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic                   m_tuser,
	input wire logic                   m_tlast
);

	// stalled cell holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output cell changed");

	// one number at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// a pad cell never closes the run
	a_pad_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tlast)
		else $error("pad cell marked last");

	// digit cells carry a decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[23:20] == 4'd0 && m_tdata[19:16] <= 4'd9)
		else $error("digit cell out of range");

	// the acceptance cycle cannot also deliver a cell that was not already pending
	a_no_cell_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid || !m_tready || $past(m_tvalid && !m_tready)
			|| m_tlast)
		else $error("cell produced straight after acceptance");

endmodule

bind padded_decimal_digit_writer pdw_checker u_pdw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.m_tlast   (m_tlast)
);

`default_nettype wire
